// ----- src/clx_pkg.sv -----
// Shared types and constants for the C-subset lexer.
// No dependencies; imported by every module of the block.
package clx_pkg;

  localparam int OUT_POS_W = 16;
  localparam int VAL_W     = 64;
  localparam int KW_COUNT  = 6;

  // Token kind codes as seen on the result channel
  localparam logic [2:0] KIND_NUMBER  = 3'd0;
  localparam logic [2:0] KIND_IDENT   = 3'd1;
  localparam logic [2:0] KIND_KEYWORD = 3'd2;
  localparam logic [2:0] KIND_PUNCT   = 3'd3;
  localparam logic [2:0] KIND_END     = 3'd4;
  localparam logic [2:0] KIND_INVALID = 3'd5;

  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_ZERO = 8'h30;

  // Byte class, worked out in the front end
  typedef enum logic [2:0] {
    CLS_SPACE,
    CLS_DIGIT,
    CLS_ALPHA,
    CLS_OPSTART,
    CLS_PUNCT,
    CLS_BAD
  } cls_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
    cls_t       cls;
  } item_t;

  typedef struct packed {
    logic [2:0]           kind;
    logic [OUT_POS_W-1:0] start_pos;
    logic [OUT_POS_W-1:0] token_len;
    logic [2:0]           keyword_id;
    logic [7:0]           punct_first;
    logic [7:0]           punct_second;
    logic [VAL_W-1:0]     number_value;
    logic                 last_of_run;
  } result_t;

  // Up to two results pushed into the result queue in one cycle
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  // Keyword text, left-aligned, zero padded
  function automatic logic [47:0] kw_word(input logic [2:0] k);
    logic [47:0] w;
    unique case (k)
      3'd0:    w = "return";
      3'd1:    w = {"if", 32'd0};
      3'd2:    w = {"else", 16'd0};
      3'd3:    w = {"for", 24'd0};
      3'd4:    w = {"while", 8'd0};
      3'd5:    w = {"int", 24'd0};
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] kw_len(input logic [2:0] k);
    logic [2:0] n;
    unique case (k)
      3'd0:    n = 3'd6;
      3'd1:    n = 3'd2;
      3'd2:    n = 3'd4;
      3'd3:    n = 3'd3;
      3'd4:    n = 3'd5;
      3'd5:    n = 3'd3;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Character idx of keyword k; zero past the end
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] idx);
    logic [47:0] w;
    w = kw_word(k) << {idx, 3'b000};
    return w[47:40];
  endfunction

endpackage

// ----- src/c_subset_lexer.sv -----
// Top level of the C-subset lexer: front end, lexer core and result queue.
// Depends on clx_pkg, clx_front, clx_core and clx_outq.
//
// Usage:
//   Source bytes enter on the in_ channel (valid/ready), one byte per item;
//   an item with in_end_of_text set flushes any open token and yields an
//   end token, then the lexer is back in its reset state for a new text.
//   Tokens leave on the out_ channel (valid/ready), one token per item;
//   out_last_of_run marks the final token caused by one input item.
// Path: an accepted input item passes the front queue register, then the result
//   queue register, before its first token can be taken.
// Throughput: one byte per cycle. Bytes that produce no token or one token
//   keep that rate; a byte that closes a token and is itself a punctuator
//   or an invalid byte produces two tokens, which leave one after the other.
//   The 4-entry result queue absorbs these; the core only takes a byte
//   while the queue has space for two tokens.
// Reset (rst_n low, synchronous): both queues empty, lexer idle, byte
//   position zero. A stalled receiver fills the result queue, then the
//   2-entry front queue, and then in_ready drops; nothing is lost.
module c_subset_lexer #(
  parameter int POS_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [clx_pkg::OUT_POS_W-1:0] out_start_pos,
  output logic [clx_pkg::OUT_POS_W-1:0] out_token_len,
  output logic [2:0]  out_keyword_id,
  output logic [7:0]  out_punct_first,
  output logic [7:0]  out_punct_second,
  output logic [clx_pkg::VAL_W-1:0] out_number_value,
  output logic        out_last_of_run
);
  import clx_pkg::*;

  // Front to core: classified byte
  item_t   item;
  logic    item_valid;
  logic    item_ready;
  // Core to result queue
  push_t   push;
  logic    room;
  result_t head;

  clx_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_code   (in_char_code),
    .in_end_of_text (in_end_of_text),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item)
  );

  clx_core #(
    .POS_BITS (POS_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .room       (room),
    .push       (push)
  );

  clx_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  // Unpack the head of the result queue onto the ports
  assign out_kind         = head.kind;
  assign out_start_pos    = head.start_pos;
  assign out_token_len    = head.token_len;
  assign out_keyword_id   = head.keyword_id;
  assign out_punct_first  = head.punct_first;
  assign out_punct_second = head.punct_second;
  assign out_number_value = head.number_value;
  assign out_last_of_run  = head.last_of_run;

endmodule

// ----- src/clx_front.sv -----
// Front end: accepts source bytes, classifies them and queues them (2 entries).
// Depends on clx_pkg.
module clx_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_char_code,
  input  logic           in_end_of_text,
  output logic           item_valid,
  input  logic           item_ready,
  output clx_pkg::item_t item
);
  import clx_pkg::*;

  item_t      q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  item_t      new_item;

  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    priority if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) r = CLS_SPACE;
    else if (c >= 8'd48 && c <= 8'd57) r = CLS_DIGIT;
    else if ((c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90) || c == 8'd95)
      r = CLS_ALPHA;
    else if (c == 8'd61 || c == 8'd33 || c == 8'd60 || c == 8'd62) r = CLS_OPSTART;
    else if ((c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
             (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126))
      r = CLS_PUNCT;
    else r = CLS_BAD;
    return r;
  endfunction

  assign in_ready   = (cnt_r != 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rd_ptr_r];
  assign push       = in_valid && in_ready;
  assign pop        = item_valid && item_ready;

  always_comb begin
    new_item.char_code   = in_char_code;
    new_item.end_of_text = in_end_of_text;
    new_item.cls         = classify(in_char_code);
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// ----- src/clx_core.sv -----
// Back end: lexer state machine; turns one queued item into up to two results.
// Depends on clx_pkg.
module clx_core #(
  parameter int POS_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_valid,
  output logic           item_ready,
  input  clx_pkg::item_t item,
  input  logic           room,
  output clx_pkg::push_t push
);
  import clx_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_IDENT,
    MODE_OP,
    MODE_ERR
  } mode_t;

  mode_t                mode_r, mode_nxt;
  logic [POS_BITS-1:0]  pos_r, pos_nxt;
  logic [POS_BITS-1:0]  tstart_r, tstart_nxt;
  logic [POS_BITS-1:0]  tlen_r, tlen_nxt;
  logic [VAL_W-1:0]     acc_r, acc_nxt;
  logic [KW_COUNT-1:0]  kwmask_r, kwmask_nxt;
  logic [7:0]           pend_r, pend_nxt;

  logic                 pop;
  logic                 f_v, s_v, do_start;
  result_t              f_tok, s_tok, flush_tok, blank;
  logic                 flush_has;
  logic [VAL_W+3:0]     prod;
  logic [2:0]           kw_id;
  logic                 kw_hit;
  logic [7:0]           c;
  logic                 is_alnum;

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    return (&v) ? v : v + POS_BITS'(1);
  endfunction

  // Drop keyword candidates that do not have char ch at offset off
  function automatic logic [KW_COUNT-1:0] mask_upd(input logic [KW_COUNT-1:0] m,
                                                   input logic [7:0] ch,
                                                   input logic [POS_BITS-1:0] off);
    logic [KW_COUNT-1:0] r;
    r = m;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (off >= POS_BITS'(kw_len(3'(k))) || kw_char(3'(k), off[2:0]) != ch) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  assign item_ready = room;
  assign pop        = item_valid && room;
  assign c          = item.char_code;
  assign is_alnum   = (item.cls == CLS_ALPHA) || (item.cls == CLS_DIGIT);

  // accum * 10 + digit, overflow shows in the top bits
  assign prod = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + (VAL_W+4)'(c[3:0]);

  // First keyword candidate whose length matches the token
  always_comb begin
    kw_id  = 3'd0;
    kw_hit = 1'b0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (kwmask_r[k] && tlen_r == POS_BITS'(kw_len(3'(k)))) begin
        kw_id  = 3'(k);
        kw_hit = 1'b1;
      end
    end
  end

  always_comb begin
    blank      = '0;
    flush_tok  = blank;
    flush_tok.start_pos = OUT_POS_W'(tstart_r);
    flush_tok.token_len = OUT_POS_W'(tlen_r);
    flush_has  = 1'b0;
    unique case (mode_r)
      MODE_NUM: begin
        flush_has              = 1'b1;
        flush_tok.kind         = KIND_NUMBER;
        flush_tok.number_value = acc_r;
      end
      MODE_IDENT: begin
        flush_has            = 1'b1;
        flush_tok.kind       = kw_hit ? KIND_KEYWORD : KIND_IDENT;
        flush_tok.keyword_id = kw_hit ? kw_id : 3'd0;
      end
      MODE_OP: begin
        flush_has             = 1'b1;
        flush_tok.kind        = KIND_PUNCT;
        flush_tok.token_len   = OUT_POS_W'(1);
        flush_tok.punct_first = pend_r;
      end
      default: flush_has = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    tstart_nxt = tstart_r;
    tlen_nxt   = tlen_r;
    acc_nxt    = acc_r;
    kwmask_nxt = kwmask_r;
    pend_nxt   = pend_r;
    f_v        = 1'b0;
    s_v        = 1'b0;
    do_start   = 1'b0;
    f_tok      = flush_tok;
    s_tok      = blank;
    s_tok.start_pos = OUT_POS_W'(pos_r);

    if (pop) begin
      if (item.end_of_text) begin
        f_v        = flush_has;
        s_v        = 1'b1;
        s_tok.kind = KIND_END;
        mode_nxt   = MODE_IDLE;
        pos_nxt    = '0;
        tstart_nxt = '0;
        tlen_nxt   = '0;
        acc_nxt    = '0;
        kwmask_nxt = '1;
        pend_nxt   = '0;
      end else begin
        pos_nxt = sat_inc(pos_r);
        unique case (mode_r)
          MODE_ERR: ;
          MODE_NUM: begin
            if (item.cls == CLS_DIGIT) begin
              acc_nxt  = (|prod[VAL_W+3:VAL_W]) ? '1 : prod[VAL_W-1:0];
              tlen_nxt = sat_inc(tlen_r);
            end else begin
              f_v      = 1'b1;
              mode_nxt = MODE_IDLE;
              do_start = 1'b1;
            end
          end
          MODE_IDENT: begin
            if (is_alnum) begin
              kwmask_nxt = mask_upd(kwmask_r, c, tlen_r);
              tlen_nxt   = sat_inc(tlen_r);
            end else begin
              f_v      = 1'b1;
              mode_nxt = MODE_IDLE;
              do_start = 1'b1;
            end
          end
          MODE_OP: begin
            f_v      = 1'b1;
            mode_nxt = MODE_IDLE;
            pend_nxt = '0;
            if (c == CH_EQ) begin
              f_tok.token_len    = OUT_POS_W'(2);
              f_tok.punct_second = c;
            end else begin
              do_start = 1'b1;
            end
          end
          default: do_start = 1'b1;
        endcase

        if (do_start) begin
          tstart_nxt = pos_r;
          tlen_nxt   = POS_BITS'(1);
          unique case (item.cls)
            CLS_SPACE: ;
            CLS_DIGIT: begin
              mode_nxt = MODE_NUM;
              acc_nxt  = VAL_W'(c - CH_ZERO);
            end
            CLS_ALPHA: begin
              mode_nxt   = MODE_IDENT;
              kwmask_nxt = mask_upd('1, c, '0);
            end
            CLS_OPSTART: begin
              mode_nxt = MODE_OP;
              pend_nxt = c;
            end
            CLS_PUNCT: begin
              s_v               = 1'b1;
              s_tok.kind        = KIND_PUNCT;
              s_tok.token_len   = OUT_POS_W'(1);
              s_tok.punct_first = c;
            end
            default: begin
              s_v               = 1'b1;
              s_tok.kind        = KIND_INVALID;
              s_tok.token_len   = OUT_POS_W'(1);
              s_tok.punct_first = c;
              mode_nxt          = MODE_ERR;
            end
          endcase
        end
      end
    end

    // Pack results in order; the final one carries last_of_run
    push.cnt = {1'b0, f_v} + {1'b0, s_v};
    push.r0  = f_v ? f_tok : s_tok;
    push.r1  = s_tok;
    push.r0.last_of_run = !(f_v && s_v);
    push.r1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= '0;
      tstart_r <= '0;
      tlen_r   <= '0;
      acc_r    <= '0;
      kwmask_r <= '1;
      pend_r   <= '0;
    end else begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      tstart_r <= tstart_nxt;
      tlen_r   <= tlen_nxt;
      acc_r    <= acc_nxt;
      kwmask_r <= kwmask_nxt;
      pend_r   <= pend_nxt;
    end
  end

endmodule

// ----- src/clx_outq.sv -----
// Result queue: 4 entries, takes up to two results a cycle, gives one while out_ready is high.
// Depends on clx_pkg.
module clx_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  clx_pkg::push_t   push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output clx_pkg::result_t head
);
  import clx_pkg::*;

  result_t    q_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  // Space for two results whatever the consumer does
  assign room      = (cnt_r <= 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign head      = q_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push.cnt;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    cnt_nxt    = cnt_r + {1'b0, push.cnt} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      q_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      q_r[wr_ptr_r + 2'd1] <= push.r1;
    end
  end

endmodule
